### hdl/trr_pkg.sv
// Shared widths, register codes, reset values and sideband types for the tick rescaler.
package trr_pkg;

  localparam int TICK_W    = 64;
  localparam int TPB_W     = 32;
  localparam int MODE_W    = 2;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_SRC_TPB = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DST_TPB = 8'd1;

  localparam logic [TPB_W-1:0] RESET_TPB = 32'd480;

  localparam logic [TICK_W-1:0] LIMIT32 = 64'h0000_0000_FFFF_FFFF;
  localparam logic [TICK_W-1:0] LIMIT64 = 64'hFFFF_FFFF_FFFF_FFFF;

  // mode bit positions
  localparam int MODE_LEN_BIT  = 0;
  localparam int MODE_WIDE_BIT = 1;

  // sideband through the first divider
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              zero_len;
  } div1_sb_t;

  // sideband through the second divider
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              zero_len;
    logic              clamp;
    logic [TICK_W-1:0] whole;
  } div2_sb_t;

  // one finished result word
  typedef struct packed {
    logic [TICK_W-1:0] scaled_tick;
    logic              saturated;
  } res_t;

  function automatic logic [TICK_W-1:0] limit_of(input logic [MODE_W-1:0] mode);
    return mode[MODE_WIDE_BIT] ? LIMIT64 : LIMIT32;
  endfunction

endpackage

### hdl/trr_div_pipe.sv
// Pipelined restoring divider: one quotient bit per register stage, sideband alongside.
module trr_div_pipe import trr_pkg::*; #(
  parameter int NUM_W = TICK_W,
  parameter int DEN_W = TPB_W,
  parameter int SB_W  = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             ce,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [DEN_W-1:0] den,
  input  logic [SB_W-1:0]  in_sb,
  output logic             out_valid,
  output logic [NUM_W-1:0] out_quo,
  output logic [DEN_W-1:0] out_rem,
  output logic [SB_W-1:0]  out_sb
);

  logic [NUM_W-1:0] v_r;
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [SB_W-1:0]  sb_r  [NUM_W];

  genvar g;
  generate
    for (g = 0; g < NUM_W; g++) begin : g_stage
      logic             prev_v;
      logic [NUM_W-1:0] prev_nq;
      logic [DEN_W-1:0] prev_rem;
      logic [SB_W-1:0]  prev_sb;
      logic [DEN_W:0]   trial;
      logic             ge;
      logic [DEN_W-1:0] rem_nxt;
      logic [NUM_W-1:0] nq_nxt;

      if (g == 0) begin : g_first
        assign prev_v   = in_valid;
        assign prev_nq  = in_num;
        assign prev_rem = '0;
        assign prev_sb  = in_sb;
      end else begin : g_rest
        assign prev_v   = v_r[g-1];
        assign prev_nq  = nq_r[g-1];
        assign prev_rem = rem_r[g-1];
        assign prev_sb  = sb_r[g-1];
      end

      always_comb begin
        trial   = {prev_rem, prev_nq[NUM_W-1]};
        ge      = (trial >= {1'b0, den});
        rem_nxt = ge ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
        nq_nxt  = {prev_nq[NUM_W-2:0], ge};
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[g] <= 1'b0;
        end else if (ce) begin
          v_r[g] <= prev_v;
        end
        if (ce) begin
          nq_r[g]  <= nq_nxt;
          rem_r[g] <= rem_nxt;
          sb_r[g]  <= prev_sb;
        end
      end
    end
  endgenerate

  assign out_valid = v_r[NUM_W-1];
  assign out_quo   = nq_r[NUM_W-1];
  assign out_rem   = rem_r[NUM_W-1];
  assign out_sb    = sb_r[NUM_W-1];

endmodule

### hdl/tick_resolution_rescaler_core.sv
// Top level of the tick rescaler: input stage, two dividers, multiply stages, output buffer.
//
// Rescales a tick from source to destination ticks per beat as whole beats times
// dest plus the remainder times dest over source, rounded half up, saturating at
// the 32-bit or 64-bit maximum; length modes map zero to zero and lift other
// results to at least one. Throughput is one word per cycle unless a full output
// buffer stalls; words pass through the two 64-stage bit-per-stage dividers
// (tick / source, then remainder*dest / source) plus input, two multiply and one
// final stage. All stages share one advance enable; a two-word output buffer lets
// input keep flowing while a result waits. Configuration writes are always taken
// (cfg_ready is tied high) and must only happen while no word is in flight.
module tick_resolution_rescaler_core import trr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [TICK_W-1:0]    in_tick,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [TICK_W-1:0]    out_scaled_tick,
  output logic                 out_saturated,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TPB_W-1:0]     cfg_data
);

  // config registers
  logic [TPB_W-1:0] src_tpb_r, dst_tpb_r;
  logic [TPB_W-1:0] src_eff, dst_eff;

  assign cfg_ready = 1'b1;
  assign src_eff   = (src_tpb_r == '0) ? TPB_W'(1) : src_tpb_r;
  assign dst_eff   = (dst_tpb_r == '0) ? TPB_W'(1) : dst_tpb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_tpb_r <= RESET_TPB;
      dst_tpb_r <= RESET_TPB;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_SRC_TPB) src_tpb_r <= cfg_data;
      if (cfg_index == CFG_DST_TPB) dst_tpb_r <= cfg_data;
    end
  end

  // global advance enable, from output buffer occupancy
  logic       ce;
  logic [1:0] cnt_r;
  logic       fin_v_r;

  assign ce       = (cnt_r != 2'd2) || out_ready || !fin_v_r;
  assign in_ready = ce;

  // input stage: mask tick to the mode width, flag a zero length
  logic              s0_v_r;
  logic [TICK_W-1:0] s0_tick_r;
  div1_sb_t          s0_sb_r;
  logic [TICK_W-1:0] tick_m;

  assign tick_m = in_tick & limit_of(in_mode);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_v_r <= 1'b0;
    end else if (ce) begin
      s0_v_r <= in_valid;
    end
    if (ce) begin
      s0_tick_r        <= tick_m;
      s0_sb_r.mode     <= in_mode;
      s0_sb_r.zero_len <= in_mode[MODE_LEN_BIT] && (tick_m == '0);
    end
  end

  // beats = tick / src, rem = tick % src
  logic              d1_v;
  logic [TICK_W-1:0] d1_quo;
  logic [TPB_W-1:0]  d1_rem;
  div1_sb_t          d1_sb;

  trr_div_pipe #(.NUM_W(TICK_W), .DEN_W(TPB_W), .SB_W($bits(div1_sb_t))) u_div1 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (s0_v_r),
    .in_num    (s0_tick_r),
    .den       (src_eff),
    .in_sb     (s0_sb_r),
    .out_valid (d1_v),
    .out_quo   (d1_quo),
    .out_rem   (d1_rem),
    .out_sb    (d1_sb)
  );

  // multiply stage: beats split into halves, plus rem * dst
  logic                m1_v_r;
  logic [2*TPB_W-1:0]  m1_hi_r, m1_lo_r, m1_prod_r;
  div1_sb_t            m1_sb_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (ce) begin
      m1_v_r <= d1_v;
    end
    if (ce) begin
      m1_hi_r   <= d1_quo[TICK_W-1:TPB_W] * dst_eff;
      m1_lo_r   <= d1_quo[TPB_W-1:0] * dst_eff;
      m1_prod_r <= d1_rem * dst_eff;
      m1_sb_r   <= d1_sb;
    end
  end

  // combine stage: whole = beats * dst, clamp when past the mode limit
  logic                      m2_v_r;
  logic [TICK_W-1:0]         m2_prod_r;
  div2_sb_t                  m2_sb_r;
  logic [TICK_W+TPB_W-1:0]   whole_w;

  assign whole_w = {m1_hi_r, {TPB_W{1'b0}}} + (TICK_W+TPB_W)'(m1_lo_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (ce) begin
      m2_v_r <= m1_v_r;
    end
    if (ce) begin
      m2_prod_r        <= m1_prod_r;
      m2_sb_r.mode     <= m1_sb_r.mode;
      m2_sb_r.zero_len <= m1_sb_r.zero_len;
      m2_sb_r.clamp    <= whole_w > (TICK_W+TPB_W)'(limit_of(m1_sb_r.mode));
      m2_sb_r.whole    <= whole_w[TICK_W-1:0];
    end
  end

  // part = rem * dst / src
  logic              d2_v;
  logic [TICK_W-1:0] d2_quo;
  logic [TPB_W-1:0]  d2_rem;
  div2_sb_t          d2_sb;

  trr_div_pipe #(.NUM_W(TICK_W), .DEN_W(TPB_W), .SB_W($bits(div2_sb_t))) u_div2 (
    .clk       (clk),
    .rst_n     (rst_n),
    .ce        (ce),
    .in_valid  (m2_v_r),
    .in_num    (m2_prod_r),
    .den       (src_eff),
    .in_sb     (m2_sb_r),
    .out_valid (d2_v),
    .out_quo   (d2_quo),
    .out_rem   (d2_rem),
    .out_sb    (d2_sb)
  );

  // final stage: round half up, add, saturate, length floor
  res_t              fin_r;
  res_t              fin_nxt;
  logic [TPB_W:0]    part;
  logic [TICK_W:0]   sum;
  logic              rnd;
  logic              clamp;
  logic [TICK_W-1:0] lim;

  always_comb begin
    lim   = limit_of(d2_sb.mode);
    rnd   = ({d2_rem, 1'b0} >= {1'b0, src_eff});
    part  = {1'b0, d2_quo[TPB_W-1:0]} + (TPB_W+1)'(rnd);
    sum   = {1'b0, d2_sb.whole} + (TICK_W+1)'(part);
    clamp = d2_sb.clamp || (sum > {1'b0, lim});
    fin_nxt.saturated   = clamp;
    fin_nxt.scaled_tick = clamp ? lim : sum[TICK_W-1:0];
    if (d2_sb.mode[MODE_LEN_BIT] && fin_nxt.scaled_tick == '0) begin
      fin_nxt.scaled_tick = TICK_W'(1);
    end
    if (d2_sb.zero_len) begin
      fin_nxt.scaled_tick = '0;
      fin_nxt.saturated   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (ce) begin
      fin_v_r <= d2_v;
    end
    if (ce) begin
      fin_r <= fin_nxt;
    end
  end

  // two-word output buffer, head in buf0
  res_t buf0_r, buf1_r;
  logic push, pop;

  assign push = fin_v_r && ce;
  assign pop  = (cnt_r != 2'd0) && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= 2'(cnt_r + {1'b0, push} - {1'b0, pop});
    end
    unique case ({push, pop})
      2'b10: begin
        if (cnt_r == 2'd0) buf0_r <= fin_r;
        else               buf1_r <= fin_r;
      end
      2'b01: begin
        buf0_r <= buf1_r;
      end
      2'b11: begin
        if (cnt_r == 2'd1) buf0_r <= fin_r;
        else begin
          buf0_r <= buf1_r;
          buf1_r <= fin_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_valid       = (cnt_r != 2'd0);
  assign out_scaled_tick = buf0_r.scaled_tick;
  assign out_saturated   = buf0_r.saturated;

endmodule

### hdl/trr_checker.sv
// Port-level checker for the tick rescaler, bound to the top level.
module trr_checker import trr_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [TICK_W-1:0] out_scaled_tick,
  input logic              out_saturated,
  input logic              cfg_ready
);

  logic [8:0] pend_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= 9'(pend_r + {8'd0, in_acc} - {8'd0, out_acc});
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_scaled_tick)
      && $stable(out_saturated))
    else $error("result word changed while stalled");

  a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != '0)
    else $error("result word without an accepted input word");

  a_sat_value: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_scaled_tick == LIMIT32
      || out_scaled_tick == LIMIT64)
    else $error("saturated result not at a mode maximum");

  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready)
    else $error("configuration port not ready");

endmodule

bind tick_resolution_rescaler_core trr_checker u_trr_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_scaled_tick (out_scaled_tick),
  .out_saturated   (out_saturated),
  .cfg_ready       (cfg_ready)
);

### test/tick_resolution_rescaler_core_check.sv
// Checker for the tick rescaler: tracks registers, predicts each result word and compares.
module tick_resolution_rescaler_core_check import trr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [MODE_W-1:0]    in_mode,
  input  logic [TICK_W-1:0]    in_tick,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic [TICK_W-1:0]    out_scaled_tick,
  input  logic                 out_saturated,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TPB_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   pending_count
);

  logic [TPB_W-1:0] src_tpb;
  logic [TPB_W-1:0] dst_tpb;
  res_t             expected_words[$];

  function automatic res_t rescale_tick(input logic [MODE_W-1:0] mode,
                                        input logic [TICK_W-1:0] tick_in,
                                        input logic [TPB_W-1:0] src_reg,
                                        input logic [TPB_W-1:0] dst_reg);
    logic [TICK_W-1:0] limit;
    logic [TICK_W-1:0] tick;
    logic [TICK_W-1:0] src;
    logic [TICK_W-1:0] dst;
    logic [TICK_W-1:0] beats;
    logic [TICK_W-1:0] rem;
    logic [TICK_W-1:0] whole;
    logic [TICK_W-1:0] prod;
    logic [TICK_W-1:0] part;
    logic              is_len;
    res_t              r;
    limit  = mode[MODE_WIDE_BIT] ? LIMIT64 : LIMIT32;
    is_len = mode[MODE_LEN_BIT];
    tick   = tick_in & limit;
    src    = (src_reg == '0) ? 64'd1 : {32'd0, src_reg};
    dst    = (dst_reg == '0) ? 64'd1 : {32'd0, dst_reg};
    r.saturated = 1'b0;
    if (src == dst) begin
      r.scaled_tick = tick;
    end else if (is_len && tick == '0) begin
      r.scaled_tick = '0;
    end else begin
      beats = tick / src;
      rem   = tick % src;
      if (beats > limit / dst) begin
        r.saturated   = 1'b1;
        r.scaled_tick = limit;
      end else begin
        whole = beats * dst;
        prod  = rem * dst;
        part  = prod / src;
        if ((prod % src) * 2 >= src) part = part + 1;
        if (part > limit - whole) begin
          r.saturated   = 1'b1;
          r.scaled_tick = limit;
        end else begin
          r.scaled_tick = whole + part;
        end
      end
      if (is_len && r.scaled_tick == '0) r.scaled_tick = 64'd1;
    end
    return r;
  endfunction

  assign pending_count = expected_words.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    res_t exp_w;
    if (!rst_n) begin
      src_tpb = RESET_TPB;
      dst_tpb = RESET_TPB;
      expected_words.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected word: scaled_tick=%h saturated=%b",
                     out_scaled_tick, out_saturated);
        end else begin
          exp_w = expected_words.pop_front();
          if (exp_w.scaled_tick !== out_scaled_tick || exp_w.saturated !== out_saturated) begin
            fail_count++;
            if (fail_count <= 10)
              $display("word mismatch: expected %h/%b, got %h/%b",
                       exp_w.scaled_tick, exp_w.saturated, out_scaled_tick, out_saturated);
          end
        end
      end
      // prediction uses the registers as they stand before this edge's write
      if (in_valid && in_ready)
        expected_words.insert(expected_words.size(),
                              rescale_tick(in_mode, in_tick, src_tpb, dst_tpb));
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_SRC_TPB) src_tpb = cfg_data;
        else if (cfg_index == CFG_DST_TPB) dst_tpb = cfg_data;
      end
    end
  end

endmodule

### test/tick_resolution_rescaler_core_test.sv
// Top of the tick rescaler testbench: clock, reset, stimulus and verdict.
module tick_resolution_rescaler_core_test import trr_pkg::*;;

  // mode codes
  localparam logic [MODE_W-1:0] MODE_POS32 = 2'd0;
  localparam logic [MODE_W-1:0] MODE_LEN32 = 2'd1;
  localparam logic [MODE_W-1:0] MODE_POS64 = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LEN64 = 2'd3;
  // index no register answers to
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 8'd7;

  localparam int DRAIN_CYCLES = 150;  // longer than the pipe is deep

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [MODE_W-1:0]    in_mode = '0;
  logic [TICK_W-1:0]    in_tick = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [TICK_W-1:0]    out_scaled_tick;
  logic                 out_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TPB_W-1:0]     cfg_data = '0;

  int fail_count;
  int pending_count;
  int send_idle_pct = 0;   // sender gap odds, percent
  int recv_idle_pct = 0;   // receiver stall odds, percent

  tick_resolution_rescaler_core u_dut (.*);

  tick_resolution_rescaler_core_check u_check (.*);

  always #6 clk = ~clk;

  // receiver: random stalls at the current odds
  always @(posedge clk)
    out_ready <= ($urandom_range(99) >= recv_idle_pct);

  // one input word; gaps come before raising valid so valid never drops mid-word
  task automatic send_word(input logic [MODE_W-1:0] m, input logic [TICK_W-1:0] t);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode  <= m;
    in_tick  <= t;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, only called with nothing in flight
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TPB_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_rates(input logic [TPB_W-1:0] s, input logic [TPB_W-1:0] d);
    wait_drained();
    write_reg(CFG_SRC_TPB, s);
    write_reg(CFG_DST_TPB, d);
  endtask

  // random tick: full range, small, or around beat boundaries of the source
  function automatic logic [TICK_W-1:0] pick_tick(input logic [TPB_W-1:0] s);
    logic [TICK_W-1:0] t;
    case ($urandom_range(4))
      0: t = {$urandom, $urandom};
      1: t = {32'd0, $urandom};
      2: t = $urandom_range(3);
      3: t = {32'd0, s} * $urandom_range(1000) + $urandom_range(2) - 1;
      default: t = {$urandom, $urandom} >> $urandom_range(63);
    endcase
    return t;
  endfunction

  initial begin : stimulus
    logic [TPB_W-1:0] src_set[6];
    logic [TPB_W-1:0] dst_set[6];
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // equal resolutions after reset: pass-through, 32-bit masking
    send_word(MODE_POS32, LIMIT64);
    send_word(MODE_LEN64, 64'd0);
    send_word(MODE_POS64, LIMIT64);
    send_word(MODE_LEN32, 64'h1234_5678_0000_0000);

    // doubling: zero length, overflow
    set_rates(32'd480, 32'd960);
    send_word(MODE_LEN32, 64'd0);
    send_word(MODE_LEN64, 64'd1);
    send_word(MODE_POS32, 64'd239);
    send_word(MODE_POS32, LIMIT32);
    send_word(MODE_POS64, LIMIT64);
    send_word(MODE_POS64, 64'd480);

    // exact maximum without clamp, then one past it
    set_rates(32'd1, 32'd3);
    send_word(MODE_POS32, 64'h5555_5555);
    send_word(MODE_POS32, 64'h5555_5556);
    send_word(MODE_POS64, 64'h5555_5555_5555_5555);
    send_word(MODE_LEN64, 64'h5555_5555_5555_5556);

    // small length rounds up to one; half rounds up
    set_rates(32'd960, 32'd1);
    send_word(MODE_LEN32, 64'd1);
    send_word(MODE_POS32, 64'd1);
    send_word(MODE_POS32, 64'd480);
    send_word(MODE_POS32, 64'd479);

    // zero registers act as one; a write to an unused index is dropped
    set_rates(32'd0, 32'd0);
    write_reg(CFG_UNUSED, 32'd1234);
    send_word(MODE_POS64, 64'hDEAD_BEEF_0000_0001);
    set_rates(32'd0, 32'd5);
    send_word(MODE_POS64, 64'h4000_0000_0000_0000);
    send_word(MODE_LEN32, 64'd7);

    // random phases across extreme and ordinary settings
    src_set = '{32'd1, 32'hFFFF_FFFF, 32'd480, 32'd96, 32'hFFFF_FFFF, $urandom};
    dst_set = '{32'hFFFF_FFFF, 32'd1, 32'd480, 32'd1920, 32'hFFFF_FFFE, $urandom};
    for (int ph = 0; ph < 6; ph++) begin
      set_rates(src_set[ph], dst_set[ph]);
      // two phases each: slow receiver, slow sender, then full rate
      send_idle_pct = (ph < 2) ? 14 : (ph < 4) ? 88 : 0;
      recv_idle_pct = (ph < 2) ? 88 : (ph < 4) ? 14 : 0;
      for (int i = 0; i < 64; i++) begin
        if (ph == 4 && i == 32) wait_drained();  // let the pipe run dry mid-phase
        send_word(MODE_W'($urandom_range(3)), pick_tick(src_set[ph]));
      end
    end
    send_idle_pct = 0;
    recv_idle_pct = 0;

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_count == 0) begin
      $display("tick_resolution_rescaler_core: match");
    end else begin
      $display("tick_resolution_rescaler_core: mismatch");
    end
    $finish;
  end

  // hang guard
  initial begin
    #3000000;
    $display("tick_resolution_rescaler_core: mismatch");
    $finish;
  end

endmodule

### files.f
hdl/trr_pkg.sv
hdl/trr_div_pipe.sv
hdl/tick_resolution_rescaler_core.sv
hdl/trr_checker.sv
test/tick_resolution_rescaler_core_check.sv
test/tick_resolution_rescaler_core_test.sv
